FILE: sv/cbt_pkg.sv
// Package for the changed block bitmap tracker.
// Holds function codes, register indexes, field widths and reset values.
// No dependencies.
package cbt_pkg;

  localparam int WORD_BITS = 32;
  localparam int DEF_MAX_BLOCKS = 65536;
  localparam int RUN_MAX = 65535;

  localparam int CNT_W = 17;
  localparam int BYTES_W = 32;
  localparam int BN_W = 16;
  localparam int LEN_W = 16;
  localparam int OFF_W = 48;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 120;

  localparam logic [CNT_W-1:0] RST_BLOCK_COUNT = 17'd65536;
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 32'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

  typedef enum logic [2:0] {
    F_MARK  = 3'd0,
    F_RANGE = 3'd1,
    F_CLEAR = 3'd2,
    F_NEXT  = 3'd3,
    F_RLE   = 3'd4,
    F_LOAD  = 3'd5
  } func_t;

endpackage

FILE: sv/cbt_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module cbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/changed_block_bitmap_tracker.sv
// Changed block bitmap tracker top level: sequencer over a word-wide bitmap RAM.
// Depends on cbt_pkg and cbt_ram.
//
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | in_tdata, in_tuser (func)
// out     | out | out_tvalid / out_tready| out_tdata, out_tuser (found), out_tlast (done)
// cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// Each bitmap word visited takes a RAM read state, then a modify or evaluate state.
// Mark visits one word; range, load and scans walk the bitmap word by word, and
// next range then adds a multiply state (S_MUL) before the result.
// Clear and load with restart sweep all DEPTH bitmap words, one word a cycle.
// After reset the same sweep runs with in_tready low.
// A finished word waits in the output register; in_tready returns once it is loaded.
module changed_block_bitmap_tracker
  import cbt_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // block_number, range_stop, restart, load_bit, load_length, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // range_offset, range_length, out_run_bit, out_run_length, changed_now, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // found
  output logic                  out_tuser,
  // done_res
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTES_W-1:0]    cfg_data
);

  localparam int PW = $clog2(MAX_BLOCKS + 1) + 1;
  localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int OB = $clog2(WORD_BITS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WR_RD, S_WR_MOD, S_SR_RD, S_SR_EV, S_RB_RD, S_RB_EV, S_MUL, S_FIN
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0]   blk_cnt_r;
  logic [BYTES_W-1:0] blk_bytes_r;
  logic [PW-1:0] total_r, scan_r, rle_r, fill_r;
  logic [PW-1:0] pos_r, hi_r, lim_r, start_r, end_r;
  logic [AW-1:0] clr_r;
  logic          v_r, boot_r;
  logic [1:0]    phase_r;
  func_t         op_r;
  logic [LEN_W-1:0] llen_r;
  logic          res_found_r, res_done_r, res_rbit_r;
  logic [OFF_W-1:0]   res_off_r;
  logic [BYTES_W-1:0] res_len_r;
  logic [LEN_W-1:0]   res_rlen_r;
  logic          out_tvalid_r, o_found_r, o_done_r, o_rbit_r;
  logic [OFF_W-1:0]   o_off_r;
  logic [BYTES_W-1:0] o_len_r;
  logic [LEN_W-1:0]   o_rlen_r;
  logic [CNT_W-1:0]   o_cnt_r;

  logic [PW-1:0] n;
  logic [31:0]   n32;
  logic [BN_W-1:0]  in_bn;
  logic [CNT_W-1:0] in_stop;
  logic          in_restart, in_lbit;
  logic [LEN_W-1:0] in_llen;
  logic [31:0]   stop32, load_hi32, rle_lim32;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic [PW-1:0]  base;
  logic [WORD_BITS-1:0] wmask, hit, cand;
  logic [OB-1:0]  hit_k;
  logic           sr_done;
  logic [PW-1:0]  sr_res_nxt;
  logic [PW-1:0]  total_nxt;
  logic [31:0]    fill_hi32;

  assign n32 = (32'(blk_cnt_r) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(blk_cnt_r);
  assign n   = PW'(n32);

  assign in_bn      = in_tdata[15:0];
  assign in_stop    = in_tdata[32:16];
  assign in_restart = in_tdata[33];
  assign in_lbit    = in_tdata[34];
  assign in_llen    = in_tdata[50:35];

  assign stop32    = (32'(in_stop) > n32) ? n32 : 32'(in_stop);
  assign fill_hi32 = (32'(fill_r) + 32'(in_llen) > n32) ? n32 : 32'(fill_r) + 32'(in_llen);
  assign load_hi32 = (32'(fill_r) >= n32) ? 32'(fill_r) : fill_hi32;
  assign rle_lim32 = (32'(pos_r) + 32'(RUN_MAX) > n32) ? n32 : 32'(pos_r) + 32'(RUN_MAX);

  assign base = {pos_r[PW-1:OB], OB'(0)};
  assign cand = v_r ? mem_rdata : ~mem_rdata;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      wmask[k] = (OB'(k) >= pos_r[OB-1:0]) && ((base + PW'(k)) < hi_r);
      hit[k]   = (OB'(k) >= pos_r[OB-1:0]) && (cand[k] || ((base + PW'(k)) >= lim_r));
    end
    hit_k = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_k = OB'(k);
      end
    end
  end

  always_comb begin
    sr_done = 1'b0;
    sr_res_nxt = pos_r;
    if (state_r == S_SR_RD && pos_r >= lim_r) begin
      sr_done = 1'b1;
    end else if (state_r == S_SR_EV && hit != '0) begin
      sr_done = 1'b1;
      sr_res_nxt = base + PW'(hit_k);
    end
  end

  always_comb begin
    if (v_r) begin
      mem_wdata = mem_rdata | wmask;
      total_nxt = total_r + PW'($countones(wmask & ~mem_rdata));
    end else begin
      mem_wdata = mem_rdata & ~wmask;
      total_nxt = total_r - PW'($countones(wmask & mem_rdata));
    end
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_addr = clr_r;
    end else begin
      mem_we = (state_r == S_WR_MOD);
      mem_addr = pos_r[AW+OB-1:OB];
    end
  end

  cbt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ((state_r == S_CLR) ? '0 : mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= RST_BLOCK_COUNT;
      blk_bytes_r <= RST_BLOCK_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_COUNT: blk_cnt_r <= cfg_data[CNT_W-1:0];
        REG_BLOCK_BYTES: blk_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      boot_r <= 1'b1;
      clr_r <= '0;
      total_r <= '0;
      scan_r <= '0;
      rle_r <= '0;
      fill_r <= '0;
      out_tvalid_r <= 1'b0;
      op_r <= F_CLEAR;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) begin
            clr_r <= '0;
            if (boot_r) begin
              boot_r <= 1'b0;
              state_r <= S_IDLE;
            end else if (op_r == F_LOAD) begin
              pos_r <= '0;
              hi_r <= (32'(llen_r) > n32) ? n : PW'(llen_r);
              state_r <= S_WR_RD;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r <= func_t'(in_tuser);
            v_r <= 1'b1;
            llen_r <= in_llen;
            phase_r <= '0;
            res_found_r <= 1'b0;
            res_done_r <= 1'b0;
            res_rbit_r <= 1'b0;
            res_off_r <= '0;
            res_len_r <= '0;
            res_rlen_r <= '0;
            state_r <= S_FIN;
            case (in_tuser)
              F_MARK: begin
                if (32'(in_bn) < n32) begin
                  pos_r <= PW'(in_bn);
                  hi_r <= PW'(in_bn) + PW'(1);
                  state_r <= S_WR_RD;
                end
              end
              F_RANGE: begin
                if (32'(in_bn) < stop32) begin
                  pos_r <= PW'(in_bn);
                  hi_r <= PW'(stop32);
                  state_r <= S_WR_RD;
                end
              end
              F_CLEAR: begin
                total_r <= '0;
                state_r <= S_CLR;
              end
              F_NEXT: begin
                pos_r <= in_restart ? '0 : scan_r;
                if (in_restart) begin
                  scan_r <= '0;
                end
                lim_r <= n;
                state_r <= S_SR_RD;
              end
              F_RLE: begin
                if (in_restart) begin
                  rle_r <= '0;
                end
                pos_r <= in_restart ? '0 : rle_r;
                if (in_restart || rle_r < n) begin
                  state_r <= S_RB_RD;
                end else begin
                  res_done_r <= 1'b1;
                end
              end
              F_LOAD: begin
                v_r <= in_lbit;
                if (in_restart) begin
                  total_r <= '0;
                  fill_r <= '0;
                  state_r <= S_CLR;
                end else begin
                  pos_r <= fill_r;
                  hi_r <= PW'(load_hi32);
                  state_r <= S_WR_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_WR_RD: begin
          if (pos_r >= hi_r) begin
            if (op_r == F_LOAD) begin
              fill_r <= hi_r;
              res_done_r <= (hi_r >= n);
            end
            state_r <= S_FIN;
          end else begin
            state_r <= S_WR_MOD;
          end
        end
        S_WR_MOD: begin
          total_r <= total_nxt;
          pos_r <= base + PW'(WORD_BITS);
          state_r <= S_WR_RD;
        end
        S_RB_RD: begin
          if (pos_r >= n) begin
            res_done_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_RB_EV;
          end
        end
        S_RB_EV: begin
          res_rbit_r <= mem_rdata[pos_r[OB-1:0]];
          v_r <= ~mem_rdata[pos_r[OB-1:0]];
          lim_r <= PW'(rle_lim32);
          state_r <= S_SR_RD;
        end
        S_SR_RD, S_SR_EV: begin
          if (sr_done) begin
            if (op_r == F_RLE) begin
              res_found_r <= 1'b1;
              res_rlen_r <= LEN_W'(sr_res_nxt - rle_r);
              rle_r <= sr_res_nxt;
              res_done_r <= (sr_res_nxt >= n);
              state_r <= S_FIN;
            end else begin
              case (phase_r)
                2'd0: begin
                  if (sr_res_nxt >= n) begin
                    res_done_r <= 1'b1;
                    if (scan_r < n) begin
                      scan_r <= n;
                    end
                    state_r <= S_FIN;
                  end else begin
                    start_r <= sr_res_nxt;
                    pos_r <= sr_res_nxt;
                    v_r <= 1'b0;
                    phase_r <= 2'd1;
                    state_r <= S_SR_RD;
                  end
                end
                2'd1: begin
                  end_r <= sr_res_nxt;
                  scan_r <= sr_res_nxt;
                  pos_r <= sr_res_nxt;
                  v_r <= 1'b1;
                  phase_r <= 2'd2;
                  state_r <= S_SR_RD;
                end
                default: begin
                  res_done_r <= (sr_res_nxt >= n);
                  res_found_r <= 1'b1;
                  state_r <= S_MUL;
                end
              endcase
            end
          end else if (state_r == S_SR_RD) begin
            state_r <= S_SR_EV;
          end else begin
            pos_r <= base + PW'(WORD_BITS);
            state_r <= S_SR_RD;
          end
        end
        S_MUL: begin
          res_off_r <= OFF_W'(64'(start_r) * 64'(blk_bytes_r));
          res_len_r <= BYTES_W'(64'(end_r - start_r) * 64'(blk_bytes_r));
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            o_found_r <= res_found_r;
            o_done_r <= res_done_r;
            o_off_r <= res_off_r;
            o_len_r <= res_len_r;
            o_rbit_r <= res_rbit_r;
            o_rlen_r <= res_rlen_r;
            o_cnt_r <= CNT_W'(total_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = o_found_r;
  assign out_tlast  = o_done_r;
  assign out_tdata  = {6'd0, o_cnt_r, o_rlen_r, o_rbit_r, o_len_r, o_off_r};

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= PW'(MAX_BLOCKS))
    else $error("changed count exceeds block capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a word while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_r <= PW'(MAX_BLOCKS)) && (rle_r <= PW'(MAX_BLOCKS)))
    else $error("scan position past capacity");

endmodule

FILE: dv/tb_top.sv
// Testbench for the changed block bitmap tracker: drives command words, predicts
// each result word with a bitmap model of its own and compares field by field.
// Depends on cbt_pkg and the tracker RTL.
`timescale 1ns / 100ps

module tb_top;
  import cbt_pkg::*;

  localparam int NBLK = DEF_MAX_BLOCKS;
  localparam int WDOG_LIMIT = 400000;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
    logic [31:0]      length;
    logic             run_bit;
    logic [LEN_W-1:0] run_len;
    logic [CNT_W-1:0] changed;
    logic             done;
  } result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTES_W-1:0] cfg_data;

  changed_block_bitmap_tracker u_top (.*);

  bit        dirty_map [NBLK];
  int unsigned dirty_total, scan_at, rle_at, fill_at;
  logic [CNT_W-1:0] cnt_reg;
  logic [31:0] bytes_reg;
  result_t   expected_q[$];
  int        errors;
  int        idle_pct;
  int        stall_pct;
  int unsigned quiet_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_blocks();
    return (cnt_reg > NBLK) ? NBLK : cnt_reg;
  endfunction

  function automatic void put_bit(int unsigned i, bit v);
    if (dirty_map[i] && !v) dirty_total--;
    else if (!dirty_map[i] && v) dirty_total++;
    dirty_map[i] = v;
  endfunction

  function automatic void wipe_map();
    foreach (dirty_map[i]) dirty_map[i] = 1'b0;
    dirty_total = 0;
  endfunction

  function automatic result_t track_cmd(func_t f, int unsigned bn, int unsigned stop,
                                       bit rs, bit lb, int unsigned ll);
    result_t r;
    int unsigned n, i, j, c;
    bit b;
    logic [63:0] prod;
    r = '0;
    n = eff_blocks();
    case (f)
      F_MARK: if (bn < n) put_bit(bn, 1'b1);
      F_RANGE: begin
        if (stop > n) stop = n;
        for (i = bn; i < stop; i++) put_bit(i, 1'b1);
      end
      F_CLEAR: wipe_map();
      F_NEXT: begin
        if (rs) scan_at = 0;
        i = scan_at;
        while (i < n && !dirty_map[i]) i++;
        if (i >= n) begin
          r.done = 1;
          if (scan_at < n) scan_at = n;
        end else begin
          j = i;
          while (j < n && dirty_map[j]) j++;
          r.found = 1;
          prod = 64'(i) * 64'(bytes_reg);
          r.offset = prod[OFF_W-1:0];
          prod = 64'(j - i) * 64'(bytes_reg);
          r.length = prod[31:0];
          scan_at = j;
          while (j < n && !dirty_map[j]) j++;
          r.done = (j >= n);
        end
      end
      F_RLE: begin
        if (rs) rle_at = 0;
        if (rle_at >= n) r.done = 1;
        else begin
          b = dirty_map[rle_at];
          c = 1;
          while (rle_at + c < n && dirty_map[rle_at + c] == b && c < RUN_MAX) c++;
          r.found = 1;
          r.run_bit = b;
          r.run_len = c[LEN_W-1:0];
          rle_at += c;
          r.done = (rle_at >= n);
        end
      end
      F_LOAD: begin
        if (rs) begin
          wipe_map();
          fill_at = 0;
        end
        for (j = 0; j < ll && fill_at < n; j++) begin
          put_bit(fill_at, lb);
          fill_at++;
        end
        r.done = (fill_at >= n);
      end
      default: ;
    endcase
    r.changed = dirty_total[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_cmd(func_t f, int unsigned bn, int unsigned stop,
                          bit rs = 0, bit lb = 0, int unsigned ll = 0);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= f;
    in_tdata <= {IN_DATA_W'(0) | {ll[15:0], lb, rs, stop[16:0], bn[15:0]}};
    expected_q.insert(expected_q.size(), track_cmd(f, bn, stop, rs, lb, ll));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_raw(logic [2:0] code, logic [IN_DATA_W-1:0] data);
    result_t r;
    r = '0;
    r.changed = dirty_total[CNT_W-1:0];
    in_tvalid <= 1;
    in_tuser <= code;
    in_tdata <= data;
    expected_q.insert(expected_q.size(), r);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_BLOCK_COUNT) cnt_reg = val[CNT_W-1:0];
    else bytes_reg = val;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[47:0], out_tdata[79:48], out_tdata[80],
             out_tdata[96:81], out_tdata[113:97], out_tlast};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.offset !== want.offset) report_mismatch("offset", got.offset, want.offset);
        if (got.length !== want.length) report_mismatch("length", got.length, want.length);
        if (got.run_bit !== want.run_bit) report_mismatch("run_bit", got.run_bit, want.run_bit);
        if (got.run_len !== want.run_len) report_mismatch("run_len", got.run_len, want.run_len);
        if (got.changed !== want.changed) report_mismatch("changed", got.changed, want.changed);
        if (got.done !== want.done) report_mismatch("done", got.done, want.done);
        if (out_tdata[OUT_DATA_W-1:114] !== '0) report_mismatch("pad", 0, 0);
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(F_MARK, 0, 0);
    send_cmd(F_MARK, 65535, 0);
    send_cmd(F_RANGE, 5, 3);
    send_cmd(F_RANGE, 100, 200, 1);
    send_cmd(F_RANGE, 65530, 131071);
    send_cmd(F_NEXT, 0, 0, 1);
    send_cmd(F_NEXT, 0, 0);
    send_cmd(F_NEXT, 0, 0);
    send_cmd(F_NEXT, 0, 0);
    send_cmd(F_RLE, 0, 0, 1);
    send_cmd(F_RLE, 0, 0);
    send_cmd(F_RLE, 0, 0);
    send_cmd(F_RLE, 0, 0);
    send_cmd(F_CLEAR, 0, 0, 1);
    send_cmd(F_NEXT, 0, 0);
    send_cmd(F_LOAD, 0, 0, 1, 1, 65535);
    send_cmd(F_LOAD, 0, 0, 0, 0, 10);
    send_cmd(F_RLE, 0, 0, 1);
    send_cmd(F_RLE, 0, 0);
    send_raw(3'd6, '1);
    send_raw(3'd7, '0);
    send_cmd(F_LOAD, 0, 0, 1, 0, 0);
  endtask

  task automatic test_small_config();
    write_reg(REG_BLOCK_COUNT, 1);
    write_reg(REG_BLOCK_BYTES, 32'hFFFF_FFFF);
    send_cmd(F_MARK, 1, 0);
    send_cmd(F_MARK, 0, 0);
    send_cmd(F_NEXT, 0, 0, 1);
    send_cmd(F_RLE, 0, 0, 1);
    send_cmd(F_RLE, 0, 0);
    send_cmd(F_LOAD, 0, 0, 1, 1, 5);
    write_reg(REG_BLOCK_COUNT, 0);
    send_cmd(F_NEXT, 0, 0, 1);
    send_cmd(F_MARK, 0, 0);
    write_reg(REG_BLOCK_COUNT, 17'h1FFFF);
    write_reg(REG_BLOCK_BYTES, 1);
    send_cmd(F_RANGE, 0, 40000);
    send_cmd(F_NEXT, 0, 0, 1);
  endtask

  task automatic test_random(int items, int unsigned nmax);
    int unsigned bn, st, ll;
    int k;
    func_t f;
    for (k = 0; k < items; k++) begin
      if (k == items / 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      if (k == items / 2) begin
        idle_pct = 11;
        stall_pct = 11;
        in_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      bn = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(nmax);
      st = ($urandom_range(9) == 0) ? $urandom_range(131071) : bn + $urandom_range(40);
      ll = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(30);
      case ($urandom_range(19))
        0: f = F_CLEAR;
        1, 2, 3: f = F_MARK;
        4, 5, 6: f = F_RANGE;
        7, 8, 9, 10: f = F_NEXT;
        11, 12, 13, 14: f = F_RLE;
        default: f = F_LOAD;
      endcase
      send_cmd(f, bn, st, $urandom_range(7) == 0, 1'($urandom_range(1)), ll);
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 11;
    stall_pct = 11;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    cnt_reg = RST_BLOCK_COUNT;
    bytes_reg = RST_BLOCK_BYTES;
    wipe_map();
    scan_at = 0;
    rle_at = 0;
    fill_at = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_small_config();
    write_reg(REG_BLOCK_COUNT, 300);
    write_reg(REG_BLOCK_BYTES, 32'h8000_0001);
    test_random(1000, 320);
    write_reg(REG_BLOCK_COUNT, 65536);
    write_reg(REG_BLOCK_BYTES, 4096);
    test_random(1000, 65535);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
